// ===== rtl/core/rpa_pkg.sv =====
`timescale 1ns / 1ps
package rpa_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP1,
        S_PREP2,
        S_LOAD,
        S_RUN,
        S_STORE,
        S_PUB
    } t_state;

    typedef struct packed {
        logic step;
        logic prep1;
        logic prep2;
        logic load;
        logic run;
        logic store;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic need_gains;
        logic div_last;
        logic sel_last;
    } t_stat;

    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_POWER    = 3'd1;
    localparam logic [2:0] REG_CYCLES   = 3'd2;
    localparam logic [2:0] REG_BAND     = 3'd3;
    localparam logic [2:0] REG_STALL    = 3'd4;
    localparam logic [2:0] REG_LIMIT    = 3'd5;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_RUNAWAY = 2'd1;
    localparam logic [1:0] FAULT_TIMEOUT = 2'd2;

    localparam logic [1:0] SEL_P = 2'd0;
    localparam logic [1:0] SEL_I = 2'd1;
    localparam logic [1:0] SEL_D = 2'd2;

    // 4 * 0.6 * 100000, 4 * 1.2 * 1000 * 100000, 4 * 0.075 * 100 / 1000 scaled
    localparam logic [17:0] C_KP = 18'd240000;
    localparam logic [28:0] C_KI = 29'd480000000;
    localparam logic [4:0]  C_KD = 5'd30;
    localparam logic [18:0] C_PI = 19'd314159;

endpackage

// ===== rtl/core/rpa_ctrl.sv =====
`timescale 1ns / 1ps
module rpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  rpa_pkg::t_stat i_stat,
    output rpa_pkg::t_cmd  o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import rpa_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP1;
            S_PREP1: n_state = i_stat.need_gains ? S_PREP2 : S_PUB;
            S_PREP2: n_state = S_LOAD;
            S_LOAD:  n_state = S_RUN;
            S_RUN:   if (i_stat.div_last) n_state = S_STORE;
            S_STORE: n_state = i_stat.sel_last ? S_PUB : S_LOAD;
            S_PUB:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.step    = i_in_valid;
            S_PREP1: o_cmd.prep1   = i_stat.need_gains;
            S_PREP2: o_cmd.prep2   = 1'b1;
            S_LOAD:  o_cmd.load    = 1'b1;
            S_RUN:   o_cmd.run     = 1'b1;
            S_STORE: o_cmd.store   = 1'b1;
            S_PUB:   o_cmd.publish = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.publish) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    a_run_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> (r_state == S_RUN || r_state == S_STORE))
        else $error("divider left mid-run");
    a_pub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> r_out_valid)
        else $error("publish without output valid");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |=> (r_state == S_PREP1))
        else $error("request accepted outside idle");

endmodule

// ===== rtl/core/rpa_dp.sv =====
`timescale 1ns / 1ps
module rpa_dp #(
    parameter int TEMP_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpa_pkg::t_cmd  i_cmd,
    output rpa_pkg::t_stat o_stat,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_func,
    input  logic [12:0]   i_temperature,
    input  logic [31:0]   i_now_ms,
    output logic [7:0]    o_heater_drive,
    output logic          o_busy_res,
    output logic          o_done_res,
    output logic [1:0]    o_fault,
    output logic [3:0]    o_cycles_done,
    output logic [31:0]   o_gain_p,
    output logic [31:0]   o_gain_i,
    output logic [31:0]   o_gain_d
);
    import rpa_pkg::*;

    localparam int S   = TEMP_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int NW  = ((45 + S > 63) ? 45 + S : 63) + 1;
    localparam int CW  = $clog2(NW);
    localparam logic [13:0] ONE_DEG = 14'(1 << TEMP_FRAC_BITS);

    // configuration
    logic [12:0] r_setpoint;
    logic [7:0]  r_power;
    logic [3:0]  r_cycles;
    logic [9:0]  r_band;
    logic [31:0] r_stall_lim, r_tune_lim;

    // tuning state
    logic        r_active, r_heating;
    logic [3:0]  r_cycle_count;
    logic [12:0] r_peak, r_trough, r_prev_temp;
    logic [31:0] r_switch_time, r_last_period, r_prev_time, r_start_time;

    // result staging and output
    logic [7:0]  r_s_drive;
    logic        r_s_busy, r_s_done;
    logic [1:0]  r_s_fault;
    logic [3:0]  r_s_cyc;
    logic [31:0] r_s_gp, r_s_gi, r_s_gd;
    logic        r_need;
    logic [12:0] r_d;

    // gain arithmetic
    logic [25:0] r_nump;
    logic [36:0] r_numi;
    logic [12:0] r_p30;
    logic [44:0] r_numd;
    logic [31:0] r_den0;
    logic [63:0] r_den1;
    logic [1:0]  r_sel;
    logic [NW-1:0] r_num;
    logic [63:0] r_den, r_rem;
    logic [31:0] r_q;
    logic        r_sat;
    logic [CW-1:0] r_cnt;

    logic [31:0] gap, elapsed;
    logic        runaway, timeout, hi_cross, lo_cross;
    logic [3:0]  cyc_inc, target;
    logic [63:0] den_mux;
    logic [NW-1:0] num_mux;
    logic [64:0] rem_sh;
    logic        ge;
    logic [31:0] quot;

    assign gap      = i_now_ms - r_prev_time;
    assign elapsed  = i_now_ms - r_start_time;
    assign runaway  = ({1'b0, i_temperature} < ({1'b0, r_prev_temp} + ONE_DEG))
                      && (gap > r_stall_lim);
    assign timeout  = elapsed > r_tune_lim;
    assign hi_cross = {1'b0, i_temperature} > ({1'b0, r_setpoint} + 14'(r_band));
    assign lo_cross = ({1'b0, i_temperature} + 14'(r_band)) < {1'b0, r_setpoint};
    assign cyc_inc  = r_cycle_count + 4'd1;
    assign target   = (r_cycles == 4'd0) ? 4'd1 : r_cycles;

    always_comb begin
        case (r_sel)
            SEL_P: begin
                den_mux = {32'd0, r_den0};
                num_mux = NW'(r_nump) << S;
            end
            SEL_I: begin
                den_mux = r_den1;
                num_mux = NW'(r_numi) << S;
            end
            default: begin
                den_mux = {32'd0, r_den0};
                num_mux = NW'(r_numd) << S;
            end
        endcase
    end

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign quot   = r_sat ? 32'hFFFF_FFFF : r_q;

    assign o_stat.need_gains = r_need;
    assign o_stat.div_last   = (r_cnt == '0);
    assign o_stat.sel_last   = (r_sel == SEL_D);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= 13'd3520;
            r_power     <= 8'd200;
            r_cycles    <= 4'd5;
            r_band      <= 10'd80;
            r_stall_lim <= 32'd20000;
            r_tune_lim  <= 32'd600000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SETPOINT: r_setpoint  <= i_cfg_data[12:0];
                REG_POWER:    r_power     <= i_cfg_data[7:0];
                REG_CYCLES:   r_cycles    <= i_cfg_data[3:0];
                REG_BAND:     r_band      <= i_cfg_data[9:0];
                REG_STALL:    r_stall_lim <= i_cfg_data;
                REG_LIMIT:    r_tune_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_heating     <= 1'b1;
            r_cycle_count <= 4'd0;
            r_peak        <= 13'd0;
            r_trough      <= 13'd0;
            r_switch_time <= 32'd0;
            r_last_period <= 32'd0;
            r_prev_temp   <= 13'd0;
            r_prev_time   <= 32'd0;
            r_start_time  <= 32'd0;
            r_need        <= 1'b0;
        end else if (i_cmd.step) begin
            r_s_drive <= 8'd0;
            r_s_busy  <= 1'b0;
            r_s_done  <= 1'b0;
            r_s_fault <= FAULT_NONE;
            r_s_cyc   <= r_cycle_count;
            r_s_gp    <= 32'd0;
            r_s_gi    <= 32'd0;
            r_s_gd    <= 32'd0;
            r_need    <= 1'b0;
            if (!i_func) begin
                r_active      <= 1'b1;
                r_heating     <= 1'b1;
                r_cycle_count <= 4'd0;
                r_s_cyc       <= 4'd0;
                r_peak        <= i_temperature;
                r_trough      <= i_temperature;
                r_switch_time <= 32'd0;
                r_last_period <= 32'd0;
                r_prev_temp   <= i_temperature;
                r_prev_time   <= i_now_ms;
                r_start_time  <= i_now_ms;
                r_s_busy      <= 1'b1;
            end else if (r_active) begin
                if (runaway) begin
                    r_active  <= 1'b0;
                    r_s_fault <= FAULT_RUNAWAY;
                end else begin
                    r_prev_temp <= i_temperature;
                    r_prev_time <= i_now_ms;
                    if (timeout) begin
                        r_active  <= 1'b0;
                        r_s_fault <= FAULT_TIMEOUT;
                    end else if (r_heating) begin
                        r_s_drive <= r_power;
                        r_s_busy  <= 1'b1;
                        if (hi_cross) begin
                            r_heating     <= 1'b0;
                            r_peak        <= i_temperature;
                            r_switch_time <= i_now_ms;
                        end
                    end else begin
                        r_s_busy <= 1'b1;
                        if (lo_cross) begin
                            r_heating     <= 1'b1;
                            r_trough      <= i_temperature;
                            r_last_period <= i_now_ms - r_switch_time;
                            r_switch_time <= i_now_ms;
                            r_cycle_count <= cyc_inc;
                            r_s_cyc       <= cyc_inc;
                            r_d <= (r_peak > i_temperature) ? r_peak - i_temperature : 13'd0;
                            if (cyc_inc >= target) begin
                                r_active <= 1'b0;
                                r_s_busy <= 1'b0;
                                r_s_done <= 1'b1;
                                r_need   <= 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (i_cmd.store) begin
            case (r_sel)
                SEL_P:   r_s_gp <= quot;
                SEL_I:   r_s_gi <= quot;
                default: r_s_gd <= quot;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep1) begin
            r_nump <= 26'(C_KP) * 26'(r_power);
            r_numi <= 37'(37'(C_KI) * 37'(r_power));
            r_p30  <= 13'(C_KD) * 13'(r_power);
            r_den0 <= 32'(32'(C_PI) * 32'(r_d));
        end
        if (i_cmd.prep2) begin
            r_numd <= 45'(45'(r_p30) * 45'(r_last_period));
            r_den1 <= 64'(r_den0) * 64'(r_last_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= SEL_P;
            r_cnt <= '0;
        end else if (i_cmd.prep2) begin
            r_sel <= SEL_P;
        end else if (i_cmd.load) begin
            r_num <= num_mux + NW'(den_mux >> 1);
            r_den <= den_mux;
            r_rem <= 64'd0;
            r_q   <= 32'd0;
            r_sat <= (den_mux == 64'd0);
            r_cnt <= CW'(NW - 1);
        end else if (i_cmd.run) begin
            r_num <= r_num << 1;
            r_rem <= ge ? 64'(rem_sh - {1'b0, r_den}) : rem_sh[63:0];
            r_q   <= {r_q[30:0], ge};
            if (ge && r_cnt >= CW'(32)) r_sat <= 1'b1;
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.store) begin
            r_sel <= r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_heater_drive <= r_s_drive;
            o_busy_res     <= r_s_busy;
            o_done_res     <= r_s_done;
            o_fault        <= r_s_fault;
            o_cycles_done  <= r_s_cyc;
            o_gain_p       <= r_s_gp;
            o_gain_i       <= r_s_gi;
            o_gain_d       <= r_s_gd;
        end
    end

endmodule

// ===== rtl/core/relay_pid_autotuner.sv =====
`timescale 1ns / 1ps
// Sequence: a sample without gains goes idle, prep1, publish; the finishing sample adds prep2
// and load, run, store for each gain, NW = max(45 + TEMP_FRAC_BITS + GAIN_FRAC_BITS, 63) + 1 being
// the dividend width of the one bit-per-cycle divider shared by the three gains.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous active low; clears control state and restores register defaults.
module relay_pid_autotuner #(
    parameter int TEMP_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [12:0] i_temperature,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_heater_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_fault,
    output logic [3:0]  o_cycles_done,
    output logic [31:0] o_gain_p,
    output logic [31:0] o_gain_i,
    output logic [31:0] o_gain_d
);
    import rpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    rpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rpa_dp #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_temperature  (i_temperature),
        .i_now_ms       (i_now_ms),
        .o_heater_drive (o_heater_drive),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_fault        (o_fault),
        .o_cycles_done  (o_cycles_done),
        .o_gain_p       (o_gain_p),
        .o_gain_i       (o_gain_i),
        .o_gain_d       (o_gain_d)
    );

endmodule

// ===== verif/relay_pid_autotuner_tb.sv =====
`timescale 1ns / 1ps
module relay_pid_autotuner_tb;
    import rpa_pkg::*;

    typedef struct {
        logic        func;
        logic [12:0] temp;
        logic [31:0] now;
    } sample_t;

    typedef struct {
        logic [7:0]  drive;
        logic        busy;
        logic        done;
        logic [1:0]  fault;
        logic [3:0]  cycles;
        logic [31:0] gp;
        logic [31:0] gi;
        logic [31:0] gd;
    } tune_res_t;

    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_SETPOINT;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic [12:0] i_temperature = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_heater_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [1:0]  o_fault;
    logic [3:0]  o_cycles_done;
    logic [31:0] o_gain_p;
    logic [31:0] o_gain_i;
    logic [31:0] o_gain_d;

    relay_pid_autotuner dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register shadow
    logic [12:0] sp_q = 13'd3520;
    logic [7:0]  pow_q = 8'd200;
    logic [3:0]  ncyc_q = 4'd5;
    logic [9:0]  band_q = 10'd80;
    logic [31:0] stall_q = 32'd20000;
    logic [31:0] limit_q = 32'd600000;

    // tuner state shadow
    logic        active_q = 1'b0;
    logic        heating_q = 1'b1;
    logic [3:0]  count_q = '0;
    logic [12:0] peak_q = '0;
    logic [12:0] trough_q = '0;
    logic [31:0] switch_q = '0;
    logic [31:0] period_q = '0;
    logic [12:0] ptemp_q = '0;
    logic [31:0] ptime_q = '0;
    logic [31:0] start_q = '0;

    sample_t   pending_samples[$];
    tune_res_t expected_res[$];
    int        fail_count = 0;
    int        cycle_count = 0;

    function automatic logic [31:0] gain_div(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        if (den == 0) return '1;
        q = (num + (den >> 1)) / den;
        return (q > 128'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function automatic tune_res_t tune_step(sample_t s);
        tune_res_t r;
        logic [31:0]  gap;
        logic [127:0] den;
        int           target;
        r = '{default: '0};
        if (s.func == 1'b0) begin
            active_q = 1'b1; heating_q = 1'b1; count_q = '0;
            peak_q = s.temp; trough_q = s.temp; switch_q = '0; period_q = '0;
            ptemp_q = s.temp; ptime_q = s.now; start_q = s.now;
            r.busy = 1'b1;
        end else if (active_q) begin
            gap = s.now - ptime_q;
            if (int'(s.temp) < int'(ptemp_q) + 16 && gap > stall_q) begin
                active_q = 1'b0; r.fault = FAULT_RUNAWAY;
            end else begin
                ptemp_q = s.temp; ptime_q = s.now;
                if (32'(s.now - start_q) > limit_q) begin
                    active_q = 1'b0; r.fault = FAULT_TIMEOUT;
                end else if (heating_q) begin
                    r.drive = pow_q; r.busy = 1'b1;
                    if (int'(s.temp) > int'(sp_q) + int'(band_q)) begin
                        heating_q = 1'b0; peak_q = s.temp; switch_q = s.now;
                    end
                end else begin
                    r.busy = 1'b1;
                    if (int'(s.temp) + int'(band_q) < int'(sp_q)) begin
                        target = (ncyc_q == 0) ? 1 : ncyc_q;
                        heating_q = 1'b1; trough_q = s.temp;
                        period_q = s.now - switch_q; switch_q = s.now;
                        count_q = count_q + 4'd1;
                        if (count_q >= target) begin
                            den = 128'(C_PI) * ((peak_q > trough_q) ? 128'(peak_q - trough_q) : 0);
                            active_q = 1'b0; r.busy = 1'b0; r.done = 1'b1;
                            r.gp = gain_div((128'(C_KP) * pow_q) << 20, den);
                            r.gi = gain_div((128'(C_KI) * pow_q) << 20, den * period_q);
                            r.gd = gain_div((128'(C_KD) * pow_q * period_q) << 20, den);
                        end
                    end
                end
            end
        end
        r.cycles = count_q;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // request driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        sample_t s;
        logic    nxt_valid;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_res.push_back(tune_step('{i_func, i_temperature, i_now_ms}));
            nxt_valid = i_in_valid && o_in_stall;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_samples.size() > 0) begin
                    s = pending_samples.pop_front();
                    i_func <= s.func;
                    i_temperature <= s.temp;
                    i_now_ms <= s.now;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // result monitor and receiver stall pattern
    logic [7:0] stall_mask = '0;
    always @(posedge i_clk) begin
        tune_res_t e;
        if (cycle_count % 256 == 0)
            stall_mask <= ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        i_out_stall <= stall_mask[cycle_count % 8];
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_res.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                fail_count++;
            end else begin
                e = expected_res.pop_front();
                if (o_heater_drive != e.drive) report("heater_drive", o_heater_drive, e.drive);
                if (o_busy_res != e.busy) report("busy", o_busy_res, e.busy);
                if (o_done_res != e.done) report("done", o_done_res, e.done);
                if (o_fault != e.fault) report("fault", o_fault, e.fault);
                if (o_cycles_done != e.cycles) report("cycles_done", o_cycles_done, e.cycles);
                if (o_gain_p != e.gp) report("gain_p", o_gain_p, e.gp);
                if (o_gain_i != e.gi) report("gain_i", o_gain_i, e.gi);
                if (o_gain_d != e.gd) report("gain_d", o_gain_d, e.gd);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SETPOINT: sp_q = val[12:0];
            REG_POWER:    pow_q = val[7:0];
            REG_CYCLES:   ncyc_q = val[3:0];
            REG_BAND:     band_q = val[9:0];
            REG_STALL:    stall_q = val;
            REG_LIMIT:    limit_q = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || expected_res.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    logic [31:0] gen_now;

    task automatic push(logic f, int t, logic [31:0] n);
        pending_samples.push_back('{f, 13'(t), n});
    endtask

    // well-formed relay run: start, then swing above and below the band
    task automatic tune_run();
        int cur, hi, lo, n, dtmax;
        hi = int'(sp_q) + int'(band_q);
        lo = int'(sp_q) - int'(band_q);
        dtmax = (stall_q > 400) ? 400 : int'(stall_q);
        cur = $urandom_range(0, 8191);
        if (lo > 0 && $urandom_range(0, 1)) cur = $urandom_range(0, lo - 1);
        push(1'b0, cur, gen_now);
        n = 0;
        for (int c = 0; c <= ncyc_q && n < 200; c++) begin
            while (cur <= hi && cur < 8191 && n < 200) begin
                cur = cur + $urandom_range(16, 300);
                if (cur > 8191) cur = 8191;
                gen_now += $urandom_range(0, dtmax);
                push(1'b1, cur, gen_now);
                n++;
            end
            while (cur >= lo && cur > 0 && n < 200) begin
                cur = cur - $urandom_range(1, 300);
                if (cur < 0) cur = 0;
                gen_now += $urandom_range(0, dtmax);
                push(1'b1, cur, gen_now);
                n++;
            end
            if (hi >= 8191 || lo <= 0) break;
        end
        // occasional stall past the stall limit
        if ($urandom_range(0, 5) == 0) begin
            gen_now += stall_q + 1;
            push(1'b1, cur, gen_now);
        end
    endtask

    task automatic noise();
        push(1'($urandom), $urandom_range(0, 8191), $urandom);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gen_now = $urandom;

        // directed: idle sample, start, extremes, restart, runaway, timeout
        push(1'b1, 100, 0);
        push(1'b0, 0, 32'hFFFF_FFF0);
        push(1'b1, 8191, 32'hFFFF_FFFF);
        push(1'b1, 8191, 32'd50);
        push(1'b1, 0, 32'd100);
        push(1'b0, 4000, 32'd1000);
        push(1'b0, 3000, 32'd2000);
        push(1'b1, 3000, 32'd30000);
        push(1'b1, 3000, 32'd30100);
        push(1'b0, 3000, 32'd0);
        push(1'b1, 3100, 32'd700000);
        push(1'b0, 8191, 32'd0);
        push(1'b1, 0, 32'd100);
        tune_run();

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    cfg_write(REG_SETPOINT, 0); cfg_write(REG_POWER, 0);
                    cfg_write(REG_CYCLES, 0); cfg_write(REG_BAND, 0);
                    cfg_write(REG_STALL, 0); cfg_write(REG_LIMIT, 0);
                end
                1: begin
                    cfg_write(REG_SETPOINT, 8191); cfg_write(REG_POWER, 255);
                    cfg_write(REG_CYCLES, 15); cfg_write(REG_BAND, 1023);
                    cfg_write(REG_STALL, '1); cfg_write(REG_LIMIT, '1);
                end
                2: begin
                    cfg_write(REG_SETPOINT, 1500); cfg_write(REG_POWER, 255);
                    cfg_write(REG_CYCLES, 15); cfg_write(REG_BAND, 0);
                    cfg_write(REG_STALL, '1); cfg_write(REG_LIMIT, '1);
                end
                default: begin
                    cfg_write(REG_SETPOINT, $urandom_range(300, 7800));
                    cfg_write(REG_POWER, $urandom_range(0, 255));
                    cfg_write(REG_CYCLES, $urandom_range(0, 15));
                    cfg_write(REG_BAND, $urandom_range(0, 300));
                    cfg_write(REG_STALL, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 500));
                    cfg_write(REG_LIMIT, $urandom_range(0, 3) ? 32'hFFFF_FFFF : $urandom);
                end
            endcase
            for (int k = 0; k < 100; k = pending_samples.size()) begin
                if ($urandom_range(0, 9) == 0) noise();
                else tune_run();
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
